@@ hw/rtl/rqa_pkg.sv @@
// ----------------------------------------------------------------------------
// rqa_pkg: shared types and constants of the aging ready queue
// Field widths, request and status codes, the queue entry type and the
// per-cell control struct used between the top level and the slot cells.
// ----------------------------------------------------------------------------
package rqa_pkg;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int PID_W    = 16;
    localparam int REM_W    = 16;
    localparam int WAIT_W   = 32;
    localparam int STARVE_W = 8;
    localparam int TICK_W   = 16;
    localparam int PIDX_W   = 4;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;
    localparam int SPOS_W   = 4;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PROMO = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DEQ_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ENQ_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_PROMO_BAD  = 2'd3;

    // Starvation limit after reset, largest reportable starved position
    localparam logic [STARVE_W-1:0] LIMIT_RST = 8'd5;
    localparam logic [SPOS_W-1:0]   SPOS_MAX  = 4'd15;

    // One queue entry
    typedef struct packed {
        logic [PID_W-1:0]    pid;
        logic [REM_W-1:0]    remaining;
        logic [WAIT_W-1:0]   wait_cnt;
        logic [STARVE_W-1:0] starve;
    } t_entry;

    // What a cell does in this cycle
    typedef enum logic [2:0] {
        CA_HOLD,
        CA_LOAD,
        CA_FROM_LEFT,
        CA_FROM_RIGHT,
        CA_TICK
    } t_cell_act;

    // Control handed to every cell
    typedef struct packed {
        t_cell_act           act;
        logic [TICK_W-1:0]   tick_amt;
        logic [STARVE_W-1:0] limit;
    } t_cell_ctl;

endpackage

@@ hw/rtl/rqa_req_if.sv @@
// ----------------------------------------------------------------------------
// rqa_req_if: request channel of the aging ready queue
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface rqa_req_if import rqa_pkg::*;;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [PID_W-1:0]    in_pid;
    logic [REM_W-1:0]    in_remaining;
    logic [WAIT_W-1:0]   in_wait;
    logic [STARVE_W-1:0] in_starve;
    logic [TICK_W-1:0]   tick_amount;
    logic [PIDX_W-1:0]   promote_index;

    modport source (
        output valid, req_type, in_pid, in_remaining, in_wait, in_starve,
               tick_amount, promote_index,
        input  ready
    );

    modport sink (
        input  valid, req_type, in_pid, in_remaining, in_wait, in_starve,
               tick_amount, promote_index,
        output ready
    );

endinterface

@@ hw/rtl/rqa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// rqa_rsp_if: result channel of the aging ready queue
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface rqa_rsp_if import rqa_pkg::*;;

    logic                valid;
    logic                ready;
    logic [PID_W-1:0]    out_pid;
    logic [REM_W-1:0]    out_remaining;
    logic [WAIT_W-1:0]   out_wait;
    logic [STARVE_W-1:0] out_starve;
    logic [STAT_W-1:0]   status;
    logic [OCC_W-1:0]    occupancy;
    logic                starved_found;
    logic [SPOS_W-1:0]   starved_pos;

    modport source (
        output valid, out_pid, out_remaining, out_wait, out_starve, status,
               occupancy, starved_found, starved_pos,
        input  ready
    );

    modport sink (
        input  valid, out_pid, out_remaining, out_wait, out_starve, status,
               occupancy, starved_found, starved_pos,
        output ready
    );

endinterface

@@ hw/rtl/rqa_cell.sv @@
// ----------------------------------------------------------------------------
// rqa_cell: one slot of the queue chain
// Holds one entry; loads a new entry, takes its left or right neighbor's
// entry, or ages its own entry with saturation. Flags itself as starved.
// ----------------------------------------------------------------------------
module rqa_cell import rqa_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_load,
    input  t_entry    i_left,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_starved
);

    t_entry            r_entry;
    t_entry            n_entry;
    logic [WAIT_W:0]   w_sum;

    // Saturating age of the held entry
    assign w_sum = {1'b0, r_entry.wait_cnt} + (WAIT_W + 1)'(i_ctl.tick_amt);

    // Pick the next entry
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.act)
            CA_HOLD:       n_entry = r_entry;
            CA_LOAD:       n_entry = i_load;
            CA_FROM_LEFT:  n_entry = i_left;
            CA_FROM_RIGHT: n_entry = i_right;
            CA_TICK: begin
                n_entry.wait_cnt = w_sum[WAIT_W] ? '1 : w_sum[WAIT_W-1:0];
                if (r_entry.starve != '1) begin
                    n_entry.starve = r_entry.starve + 1'b1;
                end
            end
            default:       n_entry = r_entry;
        endcase
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_starved = (r_entry.starve >= i_ctl.limit);

endmodule

@@ hw/rtl/ready_queue_with_aging.sv @@
// ----------------------------------------------------------------------------
// ready_queue_with_aging: bounded FIFO ready queue with aging and promotion
// Chain of DEPTH slot cells, front at position zero, with enqueue, dequeue,
// tick and promote requests and a starvation scan on every result.
// ----------------------------------------------------------------------------
// For each request item the accept edge updates all slot cells at once, the
// ST_CALC state then registers the result (front entry, count and the first
// starved slot found by a priority scan over the cells), and the result item
// is then offered in ST_OUT until taken; the next request is accepted only
// after that, so a new item waits for the last result, output stalls included.
// The queue holds up to DEPTH entries; slots not occupied are never reported.
// starve_limit is written through i_cfg_we/i_cfg_wdata and resets to 5.
module ready_queue_with_aging import rqa_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [STARVE_W-1:0] i_cfg_wdata,
    rqa_req_if.sink             i_req,
    rqa_rsp_if.source           o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
    localparam int EXT_W = CNT_W + OCC_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [STARVE_W-1:0] r_limit;
    logic [STAT_W-1:0]   r_status;
    logic                r_have_deq;
    t_entry              r_deq;

    t_entry              r_out_entry;
    logic [STAT_W-1:0]   r_out_status;
    logic [OCC_W-1:0]    r_out_occ;
    logic                r_out_found;
    logic [SPOS_W-1:0]   r_out_pos;

    logic                w_acc;
    logic                w_full;
    logic                w_empty;
    logic                w_promo_bad;
    logic [CMP_W-1:0]    w_idx_ext;
    logic [CMP_W-1:0]    w_cnt_ext;
    logic [EXT_W-1:0]    w_count_ext;
    logic [STAT_W-1:0]   w_status;
    t_entry              w_load;
    t_entry              w_promo;
    t_entry              w_front;
    logic                w_found;
    logic [SPOS_W-1:0]   w_pos;
    t_cell_act           w_act     [DEPTH];
    t_cell_ctl           w_ctl     [DEPTH];
    t_entry              w_cell    [DEPTH];
    logic                w_starved [DEPTH];

    assign w_acc       = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_idx_ext   = CMP_W'(i_req.promote_index);
    assign w_cnt_ext   = CMP_W'(r_count);
    assign w_promo_bad = (w_idx_ext >= w_cnt_ext);
    assign w_count_ext = EXT_W'(r_count);

    // Select the entry that moves to the front on promote
    always_comb begin
        w_promo = '0;
        for (int c = 0; c < DEPTH; c++) begin
            if (CMP_W'(c) == w_idx_ext) begin
                w_promo = w_cell[c];
            end
        end
    end

    // Entry loaded by a cell: the new item on enqueue, else the promoted one
    always_comb begin
        if (i_req.req_type == REQ_ENQ) begin
            w_load.pid       = i_req.in_pid;
            w_load.remaining = i_req.in_remaining;
            w_load.wait_cnt  = i_req.in_wait;
            w_load.starve    = i_req.in_starve;
        end else begin
            w_load = w_promo;
        end
    end

    // Decode the request into per-cell actions, new count and status
    always_comb begin
        n_count  = r_count;
        w_status = STAT_OK;
        for (int c = 0; c < DEPTH; c++) begin
            w_act[c] = CA_HOLD;
        end
        if (w_acc) begin
            case (i_req.req_type)
                REQ_ENQ: begin
                    if (w_full) begin
                        w_status = STAT_ENQ_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                        for (int c = 0; c < DEPTH; c++) begin
                            if (CNT_W'(c) == r_count) begin
                                w_act[c] = CA_LOAD;
                            end
                        end
                    end
                end
                REQ_DEQ: begin
                    if (w_empty) begin
                        w_status = STAT_DEQ_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                        for (int c = 0; c < DEPTH - 1; c++) begin
                            w_act[c] = CA_FROM_RIGHT;
                        end
                    end
                end
                REQ_TICK: begin
                    for (int c = 0; c < DEPTH; c++) begin
                        w_act[c] = CA_TICK;
                    end
                end
                REQ_PROMO: begin
                    if (w_promo_bad) begin
                        w_status = STAT_PROMO_BAD;
                    end else if (w_idx_ext != '0) begin
                        w_act[0] = CA_LOAD;
                        for (int c = 1; c < DEPTH; c++) begin
                            if (CMP_W'(c) <= w_idx_ext) begin
                                w_act[c] = CA_FROM_LEFT;
                            end
                        end
                    end
                end
                default: begin
                    w_status = STAT_OK;
                end
            endcase
        end
    end

    // Slot cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left = w_load;
        end else begin : g_inner_left
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_inner_right
            assign w_right = w_cell[g+1];
        end

        assign w_ctl[g] = '{act: w_act[g], tick_amt: i_req.tick_amount, limit: r_limit};

        rqa_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl[g]),
            .i_load    (w_load),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_entry   (w_cell[g]),
            .o_starved (w_starved[g])
        );
    end

    // Find the first starved occupied slot from the front
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        for (int c = DEPTH - 1; c >= 0; c--) begin
            if (w_starved[c] && (CNT_W'(c) < r_count)) begin
                w_found = 1'b1;
                w_pos   = (c > int'(SPOS_MAX)) ? SPOS_MAX : SPOS_W'(c);
            end
        end
    end

    assign w_front = w_empty ? '0 : w_cell[0];

    // Advance the item sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc) begin
                n_state = ST_CALC;
            end
            ST_CALC: n_state = ST_OUT;
            ST_OUT:  if (o_rsp.ready) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RST;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Capture the dequeued entry and status at accept
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_deq      <= w_cell[0];
            r_have_deq <= (i_req.req_type == REQ_DEQ) && !w_empty;
            r_status   <= w_status;
        end
    end

    // Register the result item
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_out_entry  <= r_have_deq ? r_deq : w_front;
            r_out_status <= r_status;
            r_out_occ    <= w_count_ext[OCC_W-1:0];
            r_out_found  <= w_found;
            r_out_pos    <= w_pos;
        end
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = (r_state == ST_OUT);
    assign o_rsp.out_pid       = r_out_entry.pid;
    assign o_rsp.out_remaining = r_out_entry.remaining;
    assign o_rsp.out_wait      = r_out_entry.wait_cnt;
    assign o_rsp.out_starve    = r_out_entry.starve;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.occupancy     = r_out_occ;
    assign o_rsp.starved_found = r_out_found;
    assign o_rsp.starved_pos   = r_out_pos;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.req_type == REQ_ENQ) && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow the queue");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.req_type == REQ_DEQ) && !w_empty)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not shrink the queue");

    a_err_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CALC) && (r_status != STAT_OK))
        |-> (r_count == $past(r_count)))
        else $error("rejected request changed the count");

endmodule

@@ verif/rqa_result_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rqa_result_checker: result predictor and comparator for the aging queue
// Watches the request and result channels and the starve limit port. It
// keeps its own copy of the queue and the limit, works out the result for
// every accepted request item and checks each accepted result, field by
// field, against the oldest expected one.
// ----------------------------------------------------------------------------
module rqa_result_checker import rqa_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [STARVE_W-1:0] i_cfg_wdata,
    rqa_req_if                  i_req_mon,
    rqa_rsp_if                  i_rsp_mon,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    // One expected result item
    typedef struct packed {
        t_entry              entry;
        logic [STAT_W-1:0]   status;
        logic [OCC_W-1:0]    occupancy;
        logic                found;
        logic [SPOS_W-1:0]   pos;
    } t_result;

    // Shadow queue, front at index zero
    t_entry              slots [DEPTH];
    int                  fill  = 0;
    logic [STARVE_W-1:0] limit = LIMIT_RST;

    t_result expected_results[$];
    int      mismatches = 0;
    int      checked    = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                 $time, checked, field, got, want);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // Apply one request to the shadow queue and queue up its result
    task automatic predict_queue_step(input logic [REQ_W-1:0] kind, input t_entry ent,
                                      input logic [TICK_W-1:0] amt,
                                      input logic [PIDX_W-1:0] pidx);
        t_result         res;
        t_entry          moved;
        logic [WAIT_W:0] sum;
        bit              have_entry;
        int              idx;
        int              i;
        res        = '0;
        have_entry = 1'b0;
        case (kind)
            REQ_ENQ: begin
                if (fill >= DEPTH) begin
                    res.status = STAT_ENQ_FULL;
                end else begin
                    slots[fill] = ent;
                    fill++;
                end
            end
            REQ_DEQ: begin
                have_entry = 1'b1;
                if (fill == 0) begin
                    res.status = STAT_DEQ_EMPTY;
                end else begin
                    res.entry = slots[0];
                    for (i = 1; i < fill; i++)
                        slots[i-1] = slots[i];
                    fill--;
                end
            end
            REQ_TICK: begin
                // Age every entry, saturating both counters
                for (i = 0; i < fill; i++) begin
                    sum = {1'b0, slots[i].wait_cnt} + (WAIT_W + 1)'(amt);
                    slots[i].wait_cnt = sum[WAIT_W] ? '1 : sum[WAIT_W-1:0];
                    if (slots[i].starve != '1)
                        slots[i].starve++;
                end
            end
            default: begin
                idx = int'(pidx);
                if (idx >= fill) begin
                    res.status = STAT_PROMO_BAD;
                end else if (idx != 0) begin
                    moved = slots[idx];
                    for (i = idx; i > 0; i--)
                        slots[i] = slots[i-1];
                    slots[0] = moved;
                end
            end
        endcase

        if (!have_entry && fill > 0)
            res.entry = slots[0];
        res.occupancy = OCC_W'(fill);

        // Scan from the front for the first starved entry
        for (i = 0; i < fill; i++) begin
            if (slots[i].starve >= limit) begin
                res.found = 1'b1;
                res.pos   = (i > 15) ? SPOS_MAX : SPOS_W'(i);
                break;
            end
        end
        expected_results.push_back(res);
    endtask

    // Compare one result item with the oldest expectation
    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending, out_pid",
                            32'(i_rsp_mon.out_pid), '0);
        end else begin
            want = expected_results.pop_front();
            check_field("out_pid", 32'(i_rsp_mon.out_pid), 32'(want.entry.pid));
            check_field("out_remaining", 32'(i_rsp_mon.out_remaining),
                        32'(want.entry.remaining));
            check_field("out_wait", i_rsp_mon.out_wait, want.entry.wait_cnt);
            check_field("out_starve", 32'(i_rsp_mon.out_starve), 32'(want.entry.starve));
            check_field("status", 32'(i_rsp_mon.status), 32'(want.status));
            check_field("occupancy", 32'(i_rsp_mon.occupancy), 32'(want.occupancy));
            check_field("starved_found", 32'(i_rsp_mon.starved_found), 32'(want.found));
            check_field("starved_pos", 32'(i_rsp_mon.starved_pos), 32'(want.pos));
        end
        checked++;
    endtask

    // Sample both channels and the limit port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            fill  = 0;
            limit = LIMIT_RST;
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready)
                check_result();
            if (i_req_mon.valid && i_req_mon.ready)
                predict_queue_step(i_req_mon.req_type,
                                   {i_req_mon.in_pid, i_req_mon.in_remaining,
                                    i_req_mon.in_wait, i_req_mon.in_starve},
                                   i_req_mon.tick_amount, i_req_mon.promote_index);
            if (i_cfg_we)
                limit = i_cfg_wdata;
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top of the aging ready queue
// Drives request items and the starve limit, takes result items with random
// and long stalls, and leaves prediction and checking to the result checker.
// A short directed run covers empty, full, saturation and promote corners;
// random phases then fill and drain the queue under several limits.
// ----------------------------------------------------------------------------
module tb import rqa_pkg::*;;

    localparam int QDEPTH        = 16;
    localparam int HOLD_LEN      = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    // Idle patterns of the two sides
    typedef enum logic [1:0] {
        TR_RX_SLOW,
        TR_TX_SLOW,
        TR_HOLD,
        TR_FREE
    } t_traffic;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [STARVE_W-1:0] cfg_wdata;
    logic [STARVE_W-1:0] mid_limit;

    int       fail_count;
    int       pending;
    int       checked;
    int       cycles      = 0;
    int       items_sent  = 0;
    int       level       = 0;
    bit       filling     = 1'b1;
    int       hold_cycles = 0;
    bit       hold_done   = 1'b0;
    t_traffic traffic     = TR_RX_SLOW;

    rqa_req_if u_req_if ();
    rqa_rsp_if u_rsp_if ();

    ready_queue_with_aging #(
        .DEPTH       (QDEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (u_req_if),
        .o_rsp       (u_rsp_if)
    );

    rqa_result_checker #(
        .DEPTH        (QDEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req_mon    (u_req_if),
        .i_rsp_mon    (u_rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, pending);
            $display("ready_queue_with_aging test failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off when asked
    initial begin
        u_rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (traffic == TR_HOLD && !hold_done) begin
                u_rsp_if.ready <= 1'b0;
                hold_cycles++;
                hold_done = (hold_cycles >= HOLD_LEN);
            end else begin
                u_rsp_if.ready <= ($urandom_range(99) >= ((traffic == TR_RX_SLOW) ? 57 :
                                   (traffic == TR_TX_SLOW) ? 14 : 0));
            end
        end
    end

    function automatic t_entry make_entry(input logic [PID_W-1:0] pid,
                                          input logic [REM_W-1:0] rem,
                                          input logic [WAIT_W-1:0] wt,
                                          input logic [STARVE_W-1:0] st);
        t_entry e;
        e.pid       = pid;
        e.remaining = rem;
        e.wait_cnt  = wt;
        e.starve    = st;
        return e;
    endfunction

    // Offer one request item and hold it until accepted
    task automatic send_request(input logic [REQ_W-1:0] kind, input t_entry ent,
                                input logic [TICK_W-1:0] amt,
                                input logic [PIDX_W-1:0] pos);
        int tx_idle;
        tx_idle = (traffic == TR_TX_SLOW) ? 57 : (traffic == TR_RX_SLOW) ? 14 : 0;
        while ($urandom_range(99) < tx_idle) begin
            u_req_if.valid <= 1'b0;
            @(posedge clk);
        end
        u_req_if.valid         <= 1'b1;
        u_req_if.req_type      <= kind;
        u_req_if.in_pid        <= ent.pid;
        u_req_if.in_remaining  <= ent.remaining;
        u_req_if.in_wait       <= ent.wait_cnt;
        u_req_if.in_starve     <= ent.starve;
        u_req_if.tick_amount   <= amt;
        u_req_if.promote_index <= pos;
        do @(posedge clk); while (!u_req_if.ready);
        // Track the fill level to steer the random mix
        case (kind)
            REQ_ENQ: if (level < QDEPTH) level++;
            REQ_DEQ: if (level > 0) level--;
            default: ;
        endcase
        items_sent++;
    endtask

    // Random request: swing between filling and draining the queue
    task automatic random_request();
        t_entry            ent;
        logic [REQ_W-1:0]  kind;
        logic [TICK_W-1:0] amt;
        logic [PIDX_W-1:0] pos;
        int                roll;
        if (level == QDEPTH)
            filling = 1'b0;
        else if (level == 0)
            filling = 1'b1;
        else if ($urandom_range(99) < 3)
            filling = !filling;

        roll = $urandom_range(99);
        if (roll < 40)
            kind = filling ? REQ_ENQ : REQ_DEQ;
        else if (roll < 55)
            kind = filling ? REQ_DEQ : REQ_ENQ;
        else if (roll < 78)
            kind = REQ_TICK;
        else
            kind = REQ_PROMO;

        ent.pid       = PID_W'($urandom);
        ent.remaining = REM_W'($urandom);
        ent.wait_cnt  = ($urandom_range(2) == 0) ? (32'hFFFF_0000 | $urandom_range(65535))
                                                 : $urandom;
        case ($urandom_range(2))
            0:       ent.starve = STARVE_W'($urandom_range(8));
            1:       ent.starve = STARVE_W'($urandom_range(255, 240));
            default: ent.starve = STARVE_W'($urandom_range(255));
        endcase

        case ($urandom_range(9))
            0:       amt = '1;
            1:       amt = '0;
            default: amt = TICK_W'($urandom_range(65535));
        endcase

        if (level > 0 && $urandom_range(99) < 85)
            pos = PIDX_W'($urandom_range(level - 1));
        else
            pos = PIDX_W'($urandom_range(15));

        send_request(kind, ent, amt, pos);
    endtask

    // Write the starve limit once the queue has gone quiet
    task automatic write_starve_limit(input logic [STARVE_W-1:0] value);
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input t_traffic tr, input logic [STARVE_W-1:0] lim,
                             input int n_items);
        write_starve_limit(lim);
        traffic = tr;
        repeat (n_items) random_request();
        u_req_if.valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        t_entry e_max;
        t_entry e_zero;
        t_entry e_near;
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        u_req_if.valid         <= 1'b0;
        u_req_if.req_type      <= REQ_ENQ;
        u_req_if.in_pid        <= '0;
        u_req_if.in_remaining  <= '0;
        u_req_if.in_wait       <= '0;
        u_req_if.in_starve     <= '0;
        u_req_if.tick_amount   <= '0;
        u_req_if.promote_index <= '0;
        e_max  = make_entry('1, '1, '1, '1);
        e_zero = make_entry('0, '0, '0, '0);
        e_near = make_entry(16'h5A3C, 16'h00FF, 32'hFFFF_FFF0, 8'd254);
        mid_limit = STARVE_W'($urandom_range(254, 2));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: dequeue, promote, tick
        send_request(REQ_DEQ, e_zero, '0, '0);
        send_request(REQ_PROMO, e_max, '0, '0);
        send_request(REQ_TICK, e_zero, '1, '0);
        // Extreme entries, then saturate wait and starvation counts
        send_request(REQ_ENQ, e_max, '0, '0);
        send_request(REQ_ENQ, e_zero, '0, '0);
        send_request(REQ_ENQ, e_near, '0, '0);
        send_request(REQ_TICK, e_zero, '1, '0);
        send_request(REQ_TICK, e_zero, '0, '0);
        // Promote: rear, front, one past the end, far out of range
        send_request(REQ_PROMO, e_zero, '0, 4'd2);
        send_request(REQ_PROMO, e_zero, '0, 4'd0);
        send_request(REQ_PROMO, e_zero, '0, 4'd3);
        send_request(REQ_PROMO, e_zero, '0, 4'd15);
        // Fill up, overfill, promote the last slot, drain one
        while (level < QDEPTH)
            send_request(REQ_ENQ, make_entry(PID_W'($urandom), REM_W'($urandom), $urandom,
                                             STARVE_W'($urandom_range(255))), '0, '0);
        send_request(REQ_ENQ, e_max, '0, '0);
        send_request(REQ_PROMO, e_zero, '0, 4'd15);
        send_request(REQ_DEQ, e_zero, '0, '0);
        u_req_if.valid <= 1'b0;

        run_phase(TR_RX_SLOW, 8'd1, 170);
        run_phase(TR_TX_SLOW, 8'd255, 170);
        run_phase(TR_HOLD, 8'd0, 100);
        run_phase(TR_FREE, mid_limit, 80);

        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d request items with starve limits 5, 1, 255, 0 and %0d,",
                 items_sent, mid_limit);
        $display("%0d results compared under random stalls and a %0d-cycle result hold-off",
                 checked, HOLD_LEN);
        if (fail_count == 0 && pending == 0) begin
            $display("ready_queue_with_aging test passed");
        end else begin
            $display("ready_queue_with_aging test failed");
        end
        $finish;
    end

endmodule

@@ ready_queue_with_aging.f @@
hw/rtl/rqa_pkg.sv
hw/rtl/rqa_req_if.sv
hw/rtl/rqa_rsp_if.sv
hw/rtl/rqa_cell.sv
hw/rtl/ready_queue_with_aging.sv
verif/rqa_result_checker.sv
verif/tb.sv
